@@ src/periodic_timer_event_bank_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the periodic timer event bank
// Clocked assertion wrappers used by the pteb_checker file.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_EVENT_BANK_TOP_ASSERT_SVH
`define PERIODIC_TIMER_EVENT_BANK_TOP_ASSERT_SVH

// plain property, sampled on the rising edge, off during reset
`define PTEB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pteb assertion failed");

// condition in one cycle implies consequence in the next
`define PTEB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `PTEB_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ src/pteb_pkg.sv @@
// ----------------------------------------------------------------------------
// pteb_pkg
// Types, constants and the control store of the timer event bank.
// ----------------------------------------------------------------------------
package pteb_pkg;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CntW     = 32;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned CmdW     = 2;

  localparam logic [CmdW-1:0] CMD_TICK   = 2'd0;
  localparam logic [CmdW-1:0] CMD_ARM    = 2'd1;
  localparam logic [CmdW-1:0] CMD_DISARM = 2'd2;

  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_DISPATCH = 3'd1,
    STEP_WRITE    = 3'd2,
    STEP_PRIME    = 3'd3,
    STEP_EVAL     = 3'd4,
    STEP_FINAL    = 3'd5
  } step_e;

  typedef enum logic [2:0] {
    COND_NONE      = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_ACCEPT = 3'd2,
    COND_IS_TICK   = 3'd3,
    COND_WALK_BUSY = 3'd4,
    COND_OUT_BUSY  = 3'd5
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  cfg_wr;
    logic  prime;
    logic  walk;
    logic  fin;
    cond_e hold_c;
    cond_e jmp_c;
    step_e target;
  } ctrl_t;

  // control store: hold_c repeats the step, jmp_c branches, else fall through
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '{in_ready: 1'b0, cfg_wr: 1'b0, prime: 1'b0, walk: 1'b0, fin: 1'b0,
          hold_c: COND_NONE, jmp_c: COND_ALWAYS, target: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.hold_c   = COND_NO_ACCEPT;
        w.jmp_c    = COND_NONE;
      end
      STEP_DISPATCH: begin
        w.jmp_c  = COND_IS_TICK;
        w.target = STEP_PRIME;
      end
      STEP_WRITE: begin
        w.cfg_wr = 1'b1;
        w.target = STEP_FINAL;
      end
      STEP_PRIME: begin
        w.prime = 1'b1;
        w.jmp_c = COND_NONE;
      end
      STEP_EVAL: begin
        w.walk   = 1'b1;
        w.hold_c = COND_WALK_BUSY;
        w.jmp_c  = COND_NONE;
      end
      STEP_FINAL: begin
        w.fin    = 1'b1;
        w.hold_c = COND_OUT_BUSY;
        w.target = STEP_IDLE;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ src/periodic_timer_event_bank_top.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_event_bank_top
// Bank of timer channels with down-counters and reload intervals, run by a
// small microprogram: arm, disarm, and a tick that walks every channel.
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                   tuser    tlast
// s_axis    in   channel, start_count, reload_int.    command  -
// m_axis    out  fired_channel                        fired    last
//
// Arm/disarm: DISPATCH, WRITE and FINAL follow the accepting step. Tick:
// DISPATCH, PRIME, EVAL, FINAL; EVAL walks one channel per cycle unless
// stalled on m_axis, via one write and one read port of the counter memory.
// Reset clears the per-channel valid bits; no clearing pass is needed.
// A result beat waits in the output register while the walk goes on.
// ----------------------------------------------------------------------------
module periodic_timer_event_bank_top #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // channel[3:0], start_count[35:4], reload_interval[67:36]
  input  logic [pteb_pkg::InDataW-1:0]  s_axis_tdata_i,
  // command[1:0]
  input  logic [pteb_pkg::CmdW-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // fired_channel[3:0]
  output logic [pteb_pkg::OutDataW-1:0] m_axis_tdata_o,
  // fired
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import pteb_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);
  localparam logic [6:0] ChanLimit = 7'(CHANNELS);

  step_e pc_q, pc_d;
  ctrl_t ctrl;
  logic  accept;

  logic [CmdW-1:0]  cmd_q;
  logic [ChanW-1:0] chan_q;
  logic [CntW-1:0]  start_q;
  logic [CntW-1:0]  reload_q;

  logic [IdxW-1:0]     idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [ChanW-1:0]    pend_chan_q, pend_chan_d;
  logic [CHANNELS-1:0] valid_q, valid_d;

  logic [CntW-1:0] cnt_mem [CHANNELS];
  logic [CntW-1:0] rel_mem [CHANNELS];
  logic [CntW-1:0] cnt_rd_q, rel_rd_q;
  logic [IdxW-1:0] rd_addr, wr_addr, chan_idx;
  logic            cnt_we, rel_we;
  logic [CntW-1:0] wr_cnt, wr_rel;

  logic [CntW-1:0] cur_cnt, cur_rel;
  logic            expire, out_free, stall, chan_ok;

  logic             push, push_fired, push_last;
  logic [ChanW-1:0] push_chan;
  logic             m_valid_q, m_valid_d;
  logic             out_fired_q;
  logic [ChanW-1:0] out_chan_q;
  logic             out_last_q;

  function automatic logic cond_true(cond_e c, logic acc, logic tick, logic wbusy,
                                     logic obusy);
    logic r;
    case (c)
      COND_NONE:      r = 1'b0;
      COND_ALWAYS:    r = 1'b1;
      COND_NO_ACCEPT: r = !acc;
      COND_IS_TICK:   r = tick;
      COND_WALK_BUSY: r = wbusy;
      COND_OUT_BUSY:  r = obusy;
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

  assign ctrl     = ucode(pc_q);
  assign accept   = s_axis_tvalid_i && ctrl.in_ready;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign chan_ok  = ({3'b000, chan_q} < ChanLimit);
  assign chan_idx = IdxW'(chan_q);
  assign cur_cnt  = valid_q[idx_q] ? cnt_rd_q : '0;
  assign cur_rel  = valid_q[idx_q] ? rel_rd_q : '0;
  assign expire   = (cur_cnt == CntW'(1));
  assign stall    = pend_q && expire && !out_free;

  // sequencer
  always_comb begin
    logic wbusy;
    wbusy = stall || (idx_q != LastIdx);
    if (cond_true(ctrl.hold_c, accept, cmd_q == CMD_TICK, wbusy, !out_free)) begin
      pc_d = pc_q;
    end else if (cond_true(ctrl.jmp_c, accept, cmd_q == CMD_TICK, wbusy, !out_free)) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = step_e'(pc_q + 3'd1);
    end
  end

  // datapath
  always_comb begin
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_chan_d = pend_chan_q;
    valid_d     = valid_q;
    cnt_we      = 1'b0;
    rel_we      = 1'b0;
    wr_addr     = idx_q;
    wr_cnt      = '0;
    wr_rel      = '0;
    push        = 1'b0;
    push_fired  = 1'b0;
    push_chan   = '0;
    push_last   = 1'b0;

    if (ctrl.cfg_wr && chan_ok && (cmd_q == CMD_ARM || cmd_q == CMD_DISARM)) begin
      wr_addr           = chan_idx;
      cnt_we            = 1'b1;
      rel_we            = 1'b1;
      wr_cnt            = (cmd_q == CMD_ARM) ? start_q : '0;
      wr_rel            = (cmd_q == CMD_ARM) ? reload_q : '0;
      valid_d[chan_idx] = 1'b1;
    end

    if (ctrl.prime) begin
      idx_d = '0;
    end

    if (ctrl.walk && !stall) begin
      if (cur_cnt != '0) begin
        cnt_we = 1'b1;
        wr_cnt = expire ? cur_rel : cur_cnt - CntW'(1);
      end
      if (expire) begin
        if (pend_q) begin
          push       = 1'b1;
          push_fired = 1'b1;
          push_chan  = pend_chan_q;
        end
        pend_d      = 1'b1;
        pend_chan_d = ChanW'(idx_q);
      end
      if (idx_q != LastIdx) begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (ctrl.fin && out_free) begin
      push        = 1'b1;
      push_fired  = pend_q;
      push_chan   = pend_chan_q;
      push_last   = 1'b1;
      pend_d      = 1'b0;
      pend_chan_d = '0;
    end

    rd_addr = idx_d;
  end

  always_comb begin
    if (push) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_chan_q <= '0;
      valid_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pend_chan_q <= pend_chan_d;
      valid_q     <= valid_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= s_axis_tuser_i;
      chan_q   <= s_axis_tdata_i[3:0];
      start_q  <= s_axis_tdata_i[35:4];
      reload_q <= s_axis_tdata_i[67:36];
    end
    if (push) begin
      out_fired_q <= push_fired;
      out_chan_q  <= push_chan;
      out_last_q  <= push_last;
    end
  end

  // counter and interval memories, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rel_we) begin
      rel_mem[wr_addr] <= wr_rel;
    end
    cnt_rd_q <= cnt_mem[rd_addr];
    rel_rd_q <= rel_mem[rd_addr];
  end

  assign s_axis_tready_o = ctrl.in_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_chan_q};
  assign m_axis_tuser_o  = out_fired_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ src/pteb_checker.sv @@
// ----------------------------------------------------------------------------
// pteb_checker
// Port-level checks on the timer event bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_timer_event_bank_top_assert.svh"

module pteb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [pteb_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);
  import pteb_pkg::*;

  logic s_beat, m_stall;

  assign s_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall = m_axis_tvalid_o && !m_axis_tready_i;

  `PTEB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_stall,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) &&
    $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
  `PTEB_ASSERT(a_idle_beat_zero, clk_i, rst_ni,
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
  `PTEB_ASSERT(a_idle_beat_last, clk_i, rst_ni,
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o)
  `PTEB_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, s_beat, !s_axis_tready_o)

endmodule

bind periodic_timer_event_bank_top pteb_checker u_pteb_checker (.*);

@@ bench/periodic_timer_event_bank_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_event_bank_checker
// Watches both streams of the timer bank. Every command beat is applied to a
// private copy of the channel counters and reload intervals. Each result beat
// is compared with the oldest predicted event. Mismatches are counted for the
// testbench top.
// ----------------------------------------------------------------------------
module periodic_timer_event_bank_checker #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // channel, start_count, reload_interval
  input  logic [pteb_pkg::InDataW-1:0]  s_axis_tdata_i,
  // command
  input  logic [pteb_pkg::CmdW-1:0]     s_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // fired_channel
  input  logic [pteb_pkg::OutDataW-1:0] m_axis_tdata_i,
  // fired
  input  logic                          m_axis_tuser_i,
  input  logic                          m_axis_tlast_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic                         fired;
    logic [pteb_pkg::ChanW-1:0]   chan;
    logic                         last;
  } timer_event_t;

  logic [pteb_pkg::CntW-1:0] down_cnt   [CHANNELS];
  logic [pteb_pkg::CntW-1:0] reload_val [CHANNELS];
  timer_event_t              event_q    [$];

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic apply_timer_command(input logic [pteb_pkg::InDataW-1:0] beat,
                                     input logic [pteb_pkg::CmdW-1:0] cmd);
    logic [pteb_pkg::ChanW-1:0] chan;
    logic [pteb_pkg::CntW-1:0]  start;
    logic [pteb_pkg::CntW-1:0]  ival;
    int                         hits [$];
    chan  = beat[3:0];
    start = beat[35:4];
    ival  = beat[67:36];
    if (cmd == pteb_pkg::CMD_TICK) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (down_cnt[i] == 32'd1) begin
          down_cnt[i] = reload_val[i];
          hits.push_back(i);
        end else if (down_cnt[i] != 32'd0) begin
          down_cnt[i] = down_cnt[i] - 32'd1;
        end
      end
      foreach (hits[k]) begin
        event_q.push_back('{fired: 1'b1, chan: hits[k][pteb_pkg::ChanW-1:0],
                            last: (k == hits.size() - 1)});
      end
      if (hits.size() == 0) begin
        event_q.push_back('{fired: 1'b0, chan: '0, last: 1'b1});
      end
    end else begin
      if (int'(chan) < CHANNELS) begin
        if (cmd == pteb_pkg::CMD_ARM) begin
          down_cnt[chan]   = start;
          reload_val[chan] = ival;
        end else if (cmd == pteb_pkg::CMD_DISARM) begin
          down_cnt[chan]   = '0;
          reload_val[chan] = '0;
        end
      end
      event_q.push_back('{fired: 1'b0, chan: '0, last: 1'b1});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_event_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        down_cnt[i]   = '0;
        reload_val[i] = '0;
      end
      event_q.delete();
      fail_count_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_timer_command(s_axis_tdata_i, s_axis_tuser_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (event_q.size() == 0) begin
          note_mismatch("beat with nothing pending, tdata", m_axis_tdata_i, -1);
        end else begin
          want = event_q.pop_front();
          if (m_axis_tuser_i !== want.fired)
            note_mismatch("fired", m_axis_tuser_i, want.fired);
          if (m_axis_tdata_i !== {{(pteb_pkg::OutDataW-pteb_pkg::ChanW){1'b0}}, want.chan})
            note_mismatch("fired_channel", m_axis_tdata_i, want.chan);
          if (m_axis_tlast_i !== want.last)
            note_mismatch("last", m_axis_tlast_i, want.last);
        end
      end
    end
    pending_o = event_q.size();
  end

endmodule

@@ bench/periodic_timer_event_bank_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_event_bank_top_tb
// Drives arm, disarm, tick and spare commands into the timer bank: a directed
// opening, then random traffic with mostly short counts so channels expire
// often; a burst amid it fires every channel on each tick. Streams stall
// at random. The checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module periodic_timer_event_bank_top_tb;

  localparam int unsigned        NUM_CH     = 16;
  localparam int                 RAND_BEATS = 324;
  localparam int                 QUIET_MAX  = 3000;
  localparam logic [1:0]         CMD_SPARE  = 2'd3;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [pteb_pkg::InDataW-1:0]  s_axis_tdata_i;
  logic [pteb_pkg::CmdW-1:0]     s_axis_tuser_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [pteb_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          m_axis_tuser_o;
  logic                          m_axis_tlast_o;

  int   fail_count;
  int   pending;
  int   quiet_cycles;
  logic no_gap;

  periodic_timer_event_bank_top #(
    .CHANNELS(NUM_CH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  periodic_timer_event_bank_checker #(
    .CHANNELS(NUM_CH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= no_gap || ($urandom_range(99) >= 21);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [pteb_pkg::InDataW-1:0] pack_data(
    input logic [3:0] chan, input logic [31:0] start, input logic [31:0] ival);
    return {4'h0, ival, start, chan};
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(6);
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] cmd,
                           input logic [pteb_pkg::InDataW-1:0] beat);
    @(negedge clk_i);
    while (!no_gap && $urandom_range(99) < 21) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= beat;
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_op(input logic [1:0] cmd, input logic [3:0] chan,
                         input logic [31:0] start, input logic [31:0] ival);
    send_beat(cmd, pack_data(chan, start, ival));
  endtask

  // hold the sender until every predicted event has been seen
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random_op();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)
      send_op(pteb_pkg::CMD_TICK, 4'($urandom), $urandom, $urandom);
    else if (pick < 78)
      send_op(pteb_pkg::CMD_ARM, 4'($urandom), pick_count(), pick_count());
    else if (pick < 93)
      send_op(pteb_pkg::CMD_DISARM, 4'($urandom), $urandom, $urandom);
    else
      send_op(CMD_SPARE, 4'($urandom), $urandom, $urandom);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    no_gap          = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty tick, spare code, one-shot, periodic, extreme counts
    send_op(pteb_pkg::CMD_TICK, 4'hF, '1, '1);
    send_op(CMD_SPARE, 4'hF, '1, '1);
    send_op(pteb_pkg::CMD_ARM, 4'd0, 32'd1, 32'd0);
    send_op(pteb_pkg::CMD_ARM, 4'd15, 32'd1, 32'd1);
    send_op(pteb_pkg::CMD_ARM, 4'd7, 32'd2, 32'hFFFF_FFFF);
    send_op(pteb_pkg::CMD_ARM, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(pteb_pkg::CMD_ARM, 4'd9, 32'd0, 32'd5);
    repeat (3) send_op(pteb_pkg::CMD_TICK, 4'd0, '0, '0);
    send_op(pteb_pkg::CMD_DISARM, 4'd15, '0, '0);
    send_op(pteb_pkg::CMD_DISARM, 4'd4, '1, '1);
    send_op(pteb_pkg::CMD_TICK, 4'd0, '0, '0);
    send_op(pteb_pkg::CMD_ARM, 4'd10, 32'd3, 32'd2);
    repeat (5) send_op(pteb_pkg::CMD_TICK, 4'd0, '0, '0);
    send_op(pteb_pkg::CMD_DISARM, 4'd8, '0, '0);
    send_op(pteb_pkg::CMD_DISARM, 4'd7, '0, '0);
    send_op(pteb_pkg::CMD_DISARM, 4'd10, '0, '0);
    wait_drained();

    for (int i = 0; i < RAND_BEATS; i++) begin
      no_gap = (i >= 120 && i < 200);
      if (i == 150) begin
        // every channel expires on every tick
        for (int c = 0; c < NUM_CH; c++)
          send_op(pteb_pkg::CMD_ARM, 4'(c), 32'd1, 32'd1);
        repeat (3) send_op(pteb_pkg::CMD_TICK, 4'($urandom), $urandom, $urandom);
      end
      if (i == 250) wait_drained();
      send_random_op();
    end
    no_gap = 1'b0;

    wait_drained();
    repeat (NUM_CH + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
